>>> rtl/core/bfss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfss_pkg;

    localparam int MAX_RADIUS  = 8;
    localparam int MAX_WIDTH   = 2048;
    localparam int PIXEL_BITS  = 16;

    localparam int RING_DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int SLOT_BITS   = $clog2(RING_DEPTH);
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ADDR_BITS   = $clog2(RING_DEPTH * MAX_WIDTH);

    localparam int PIX_PORT_BITS = 16;
    localparam int RADIUS_BITS   = 4;
    localparam int WIDTH_BITS    = 12;
    localparam int RECIP_BITS    = 25;
    localparam int ROW_BITS      = 16;
    localparam int COLSUM_BITS   = 21;
    localparam int TOTAL_BITS    = 25;
    localparam int PROD_BITS     = TOTAL_BITS + RECIP_BITS;
    localparam int MEAN_BITS     = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 25;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RECIPROCAL = 2'd2;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET     = 4'd1;
    localparam logic [WIDTH_BITS-1:0]  LINE_WIDTH_RESET = 12'd1024;
    localparam logic [RECIP_BITS-1:0]  RECIPROCAL_RESET = 25'd1864135;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pix;
        logic [COL_BITS-1:0]   x;
        logic [SLOT_BITS-1:0]  slot;
        logic                  first_row;
        logic                  use_old;
        logic                  x_zero;
        logic                  x_ge_n;
        logic                  emit;
        logic                  line_end;
    } col_stage_t;

    typedef struct packed {
        logic [COLSUM_BITS-1:0] colsum;
        logic                   x_zero;
        logic                   x_ge_n;
        logic                   emit;
        logic                   line_end;
    } row_stage_t;

endpackage

`default_nettype wire

>>> rtl/core/box_filter_sliding_sum_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming box filter: accepts one border-replicated pixel per clock in raster order while
// in_ready is high and produces the rounded mean of each full (2r+1)x(2r+1) window. The
// pixel that completes it runs through a registered read of the line store and column-sum
// memory, the column-sum update, the horizontal running sum and a 25x25 bit product before
// the output register; the pipeline stalls only when a result reaches the product stage
// while the output register is still full. The line store holds 17 rows of 2048 samples
// and needs no clearing after reset, since every entry is written before it is read.
module box_filter_sliding_sum_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [bfss_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [bfss_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [bfss_pkg::PIX_PORT_BITS-1:0]   pixel,
    input  wire logic                                 frame_start,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [bfss_pkg::MEAN_BITS-1:0]            mean,
    output logic                                      line_end
);
    import bfss_pkg::*;

    logic [RADIUS_BITS-1:0] radius_reg;
    logic [WIDTH_BITS-1:0]  line_width_reg;
    logic [RECIP_BITS-1:0]  reciprocal_reg;

    logic [COL_BITS-1:0]  col_reg, col_next;
    logic [ROW_BITS-1:0]  row_reg, row_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;

    logic       s1_valid_reg;
    col_stage_t s1_reg, s1_next;
    logic       s2_valid_reg;
    row_stage_t s2_reg, s2_next;
    logic                   s3_emit_reg;
    logic                   s3_line_end_reg;
    logic [PROD_BITS-1:0]   s3_prod_reg;
    logic                   out_valid_reg;
    logic [MEAN_BITS-1:0]   mean_reg, mean_next;
    logic                   line_end_reg;

    logic [PIXEL_BITS-1:0]  row_store [RING_DEPTH * MAX_WIDTH];
    logic [COLSUM_BITS-1:0] column_sums [MAX_WIDTH];
    logic [PIXEL_BITS-1:0]  old_pix_reg;
    logic [COLSUM_BITS-1:0] colsum_rd_reg;

    logic [COLSUM_BITS-1:0] sum_window_reg [RING_DEPTH];
    logic [TOTAL_BITS-1:0]  total_reg, total_next;

    logic                   adv, accept;
    logic [RADIUS_BITS-1:0] r_eff;
    logic [SLOT_BITS-1:0]   n_win, n_m1;
    logic [WIDTH_BITS-1:0]  w_eff;
    logic [COL_BITS-1:0]    col_base, x;
    logic [ROW_BITS-1:0]    row_base;
    logic [SLOT_BITS-1:0]   slot_base, slot_cur;
    logic                   last_col;
    logic [ADDR_BITS-1:0]   rd_addr, wr_addr;
    logic [COLSUM_BITS-1:0] sw_old;
    logic [PROD_BITS:0]     rounded;

    // Configuration
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            radius_reg     <= RADIUS_RESET;
            line_width_reg <= LINE_WIDTH_RESET;
            reciprocal_reg <= RECIPROCAL_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_RADIUS:     radius_reg     <= cfg_data[RADIUS_BITS-1:0];
                REG_LINE_WIDTH: line_width_reg <= cfg_data[WIDTH_BITS-1:0];
                REG_RECIPROCAL: reciprocal_reg <= cfg_data[RECIP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (radius_reg == '0) begin
            r_eff = RADIUS_BITS'(1);
        end else if (radius_reg > RADIUS_BITS'(MAX_RADIUS)) begin
            r_eff = RADIUS_BITS'(MAX_RADIUS);
        end else begin
            r_eff = radius_reg;
        end
        n_m1  = SLOT_BITS'({r_eff, 1'b0});
        n_win = n_m1 + SLOT_BITS'(1);
        if (line_width_reg == '0) begin
            w_eff = WIDTH_BITS'(1);
        end else if (line_width_reg > WIDTH_BITS'(MAX_WIDTH)) begin
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            w_eff = line_width_reg;
        end
    end

    // Flow control: only a result waiting in the product stage can hold the pipeline.
    assign adv      = !(s3_emit_reg && out_valid_reg && !out_ready);
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    // Position of the incoming beat within the frame
    always_comb begin
        col_base  = frame_start ? '0 : col_reg;
        row_base  = frame_start ? '0 : row_reg;
        slot_base = frame_start ? '0 : slot_reg;
        slot_cur  = (slot_base >= n_win) ? '0 : slot_base;
        x         = ({1'b0, col_base} >= w_eff) ? '0 : col_base;
        last_col  = ({1'b0, x} + WIDTH_BITS'(1)) >= w_eff;

        col_next  = last_col ? '0 : x + COL_BITS'(1);
        row_next  = row_base;
        slot_next = slot_cur;
        if (last_col) begin
            if (row_base != {ROW_BITS{1'b1}}) begin
                row_next = row_base + ROW_BITS'(1);
            end
            slot_next = (slot_cur + SLOT_BITS'(1) >= n_win) ? '0 : slot_cur + SLOT_BITS'(1);
        end

        s1_next.pix       = pixel[PIXEL_BITS-1:0];
        s1_next.x         = x;
        s1_next.slot      = slot_cur;
        s1_next.first_row = (row_base == '0);
        s1_next.use_old   = (row_base >= ROW_BITS'(n_win));
        s1_next.x_zero    = (x == '0);
        s1_next.x_ge_n    = (x >= COL_BITS'(n_win));
        s1_next.emit      = ({1'b0, row_base} + (ROW_BITS + 1)'(1) >= (ROW_BITS + 1)'(n_win))
                            && ({1'b0, x} + WIDTH_BITS'(1) >= WIDTH_BITS'(n_win));
        s1_next.line_end  = ({1'b0, x} == w_eff - WIDTH_BITS'(1));

        rd_addr = (ADDR_BITS'(slot_cur) << COL_BITS) | ADDR_BITS'(x);
        wr_addr = (ADDR_BITS'(s1_reg.slot) << COL_BITS) | ADDR_BITS'(s1_reg.x);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // Line store and column sums: read as a beat enters, written one stage later.
    always_ff @(posedge clk) begin
        if (adv && s1_valid_reg) begin
            row_store[wr_addr] <= s1_reg.pix;
        end
        if (adv) begin
            old_pix_reg <= row_store[rd_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (adv && s1_valid_reg) begin
            column_sums[s1_reg.x] <= s2_next.colsum;
        end
        if (adv) begin
            colsum_rd_reg <= column_sums[x];
        end
    end

    // Vertical update
    always_comb begin
        if (s1_reg.first_row) begin
            s2_next.colsum = COLSUM_BITS'(s1_reg.pix);
        end else begin
            s2_next.colsum = colsum_rd_reg + COLSUM_BITS'(s1_reg.pix)
                             - (s1_reg.use_old ? COLSUM_BITS'(old_pix_reg) : '0);
        end
        s2_next.x_zero   = s1_reg.x_zero;
        s2_next.x_ge_n   = s1_reg.x_ge_n;
        s2_next.emit     = s1_reg.emit;
        s2_next.line_end = s1_reg.line_end;
    end

    // Horizontal update over the last 2r+1 column sums of the line.
    always_comb begin
        sw_old = sum_window_reg[n_m1];
        if (s2_reg.x_zero) begin
            total_next = TOTAL_BITS'(s2_reg.colsum);
        end else begin
            total_next = total_reg + TOTAL_BITS'(s2_reg.colsum)
                         - (s2_reg.x_ge_n ? TOTAL_BITS'(sw_old) : '0);
        end
    end

    always_ff @(posedge clk) begin
        if (adv && s2_valid_reg) begin
            sum_window_reg[0] <= s2_reg.colsum;
            for (int i = 1; i < RING_DEPTH; i++) begin
                sum_window_reg[i] <= sum_window_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            total_reg <= '0;
        end else if (adv && s2_valid_reg) begin
            total_reg <= total_next;
        end
    end

    // Pipeline registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_emit_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_emit_reg  <= s2_valid_reg && s2_reg.emit;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            s1_reg          <= s1_next;
            s2_reg          <= s2_next;
            s3_prod_reg     <= PROD_BITS'(total_next) * PROD_BITS'(reciprocal_reg);
            s3_line_end_reg <= s2_reg.line_end;
        end
    end

    // Rounding, saturation and the output register
    always_comb begin
        rounded = (PROD_BITS + 1)'(s3_prod_reg) + ((PROD_BITS + 1)'(1) << 23);
        if (|rounded[PROD_BITS:24 + MEAN_BITS]) begin
            mean_next = {MEAN_BITS{1'b1}};
        end else begin
            mean_next = rounded[24 + MEAN_BITS - 1:24];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv && s3_emit_reg) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (adv && s3_emit_reg) begin
            mean_reg     <= mean_next;
            line_end_reg <= s3_line_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign mean      = mean_reg;
    assign line_end  = line_end_reg;

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        s3_emit_reg && !adv |=> s3_emit_reg && $stable(s3_prod_reg))
        else $error("Result in the product stage was lost during a stall.");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s3_emit_reg && adv))
        else $error("Output beat appeared without a result from the product stage.");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < SLOT_BITS'(RING_DEPTH))
        else $error("Line store slot pointer is out of range.");

endmodule

`default_nettype wire

>>> tb/box_filter_sliding_sum_top_tb.sv
`timescale 1ns / 1ps

module box_filter_sliding_sum_top_tb;

    import bfss_pkg::*;

    localparam int unsigned CLOCK_LIMIT      = 100_000;
    localparam int unsigned DRAIN_CYCLES     = 10;
    localparam int unsigned RESET_TEST_WIDTH = 6;
    localparam int unsigned RANDOM_ITEMS     = 500;
    localparam logic [RECIP_BITS-1:0] RECIP_MAX = '1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {PIX_RANDOM, PIX_MAX, PIX_ZERO, PIX_MIXED} pixel_kind_t;
    typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_TOGGLE} rx_mode_t;

    typedef struct packed {
        logic [MEAN_BITS-1:0] mean;
        logic                 line_end;
    } mean_beat_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [PIX_PORT_BITS-1:0]  pixel = '0;
    logic                      frame_start = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [MEAN_BITS-1:0]      mean;
    logic                      line_end;

    // Shadow copy of the register file and of the filter state.
    logic [RADIUS_BITS-1:0]    cur_radius = RADIUS_RESET;
    logic [WIDTH_BITS-1:0]     cur_line_width = LINE_WIDTH_RESET;
    logic [RECIP_BITS-1:0]     cur_reciprocal = RECIPROCAL_RESET;
    bit [PIXEL_BITS-1:0]       line_store [RING_DEPTH*MAX_WIDTH];
    bit [COLSUM_BITS-1:0]      column_totals [MAX_WIDTH];
    bit [COLSUM_BITS-1:0]      recent_columns [RING_DEPTH];
    bit [TOTAL_BITS-1:0]       window_sum;
    bit [COL_BITS-1:0]         next_column;
    bit [ROW_BITS-1:0]         next_row;
    bit [SLOT_BITS-1:0]        ring_slot;

    mean_beat_t                expected_means [$];
    mean_beat_t                oldest_mean;
    int unsigned               mismatches = 0;
    int unsigned               means_seen = 0;
    int unsigned               pixels_sent = 0;
    int unsigned               settings_used = 0;
    int unsigned               cycle_count = 0;
    int unsigned               burst_left = 0;
    rx_mode_t                  ready_mode = RX_ALWAYS;
    int unsigned               ready_left = 0;

    box_filter_sliding_sum_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mean        (mean),
        .line_end    (line_end)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CLOCK_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d means outstanding.",
                     cycle_count, expected_means.size());
            $display("box_filter_sliding_sum_top test failed");
            $finish;
        end
    end

    function automatic int unsigned clamp_radius(input int unsigned r);
        return (r < 1) ? 1 : (r > MAX_RADIUS) ? MAX_RADIUS : r;
    endfunction

    function automatic int unsigned clamp_width(input int unsigned w);
        return (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    endfunction

    function automatic int unsigned area_reciprocal(input int unsigned n);
        return ((1 << 24) + (n * n) / 2) / (n * n);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] with_junk(input int unsigned value,
                                                           input int unsigned bits);
        return CFG_DATA_BITS'(($urandom << bits) | (value & ((1 << bits) - 1)));
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pick_pixel(input pixel_kind_t kind);
        case (kind)
            PIX_MAX:   return '1;
            PIX_ZERO:  return '0;
            PIX_MIXED:
            begin
                case ($urandom_range(0, 7))
                    0:       return '0;
                    1:       return '1;
                    default: return PIXEL_BITS'($urandom);
                endcase
            end
            default:   return PIXEL_BITS'($urandom);
        endcase
    endfunction

    function automatic void predict_window_mean(input logic [PIXEL_BITS-1:0] pix,
                                                input logic starts_frame);
        int unsigned            n;
        int unsigned            w;
        int unsigned            x;
        int unsigned            addr;
        int unsigned            hist;
        logic [PIXEL_BITS-1:0]  leaving_pixel;
        logic [COLSUM_BITS-1:0] column_sum;
        logic [COLSUM_BITS-1:0] leaving_column;
        logic [PROD_BITS-1:0]   product;
        mean_beat_t             beat;

        n = 2 * clamp_radius(cur_radius) + 1;
        w = clamp_width(cur_line_width);
        if (starts_frame)
        begin
            next_column = '0;
            next_row = '0;
            ring_slot = '0;
            window_sum = '0;
        end
        if (ring_slot >= n)
            ring_slot = '0;
        if (next_column >= w)
            next_column = '0;
        x = next_column;

        addr = ring_slot * MAX_WIDTH + x;
        leaving_pixel = (next_row >= n) ? line_store[addr] : '0;
        line_store[addr] = pix;
        column_sum = (next_row == 0) ? COLSUM_BITS'(pix)
                                     : column_totals[x] + COLSUM_BITS'(pix)
                                       - COLSUM_BITS'(leaving_pixel);
        column_totals[x] = column_sum;

        hist = x % n;
        leaving_column = (x >= n) ? recent_columns[hist] : '0;
        recent_columns[hist] = column_sum;
        window_sum = (x == 0) ? TOTAL_BITS'(column_sum)
                              : window_sum + TOTAL_BITS'(column_sum)
                                - TOTAL_BITS'(leaving_column);

        if (next_row + 1 >= n && x + 1 >= n)
        begin
            product = PROD_BITS'(window_sum) * PROD_BITS'(cur_reciprocal)
                      + (PROD_BITS'(1) << 23);
            product = product >> 24;
            beat.mean = (product > PROD_BITS'(16'hFFFF)) ? '1 : product[MEAN_BITS-1:0];
            beat.line_end = (x == w - 1);
            expected_means.push_back(beat);
        end

        if (x + 1 >= w)
        begin
            next_column = '0;
            if (next_row != '1)
                next_row = next_row + ROW_BITS'(1);
            ring_slot = (ring_slot + 1 >= n) ? '0 : ring_slot + SLOT_BITS'(1);
        end
        else
            next_column = COL_BITS'(x + 1);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            means_seen++;
            if (expected_means.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected beat: mean %0d line_end %0b", mean, line_end);
            end
            else
            begin
                oldest_mean = expected_means.pop_front();
                if (mean !== oldest_mean.mean || line_end !== oldest_mean.line_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Beat %0d: mean expected %0d got %0d, line_end expected %0b got %0b",
                                 means_seen, oldest_mean.mean, mean,
                                 oldest_mean.line_end, line_end);
                end
            end
        end

        if (ready_left == 0)
        begin
            ready_mode <= rx_mode_t'($urandom_range(0, 3));
            ready_left <= $urandom_range(8, 120);
        end
        else
            ready_left <= ready_left - 1;

        case (ready_mode)
            RX_ALWAYS: out_ready <= 1'b1;
            RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
            RX_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= ~out_ready;
        endcase
    end

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input logic starts_frame);
        in_valid <= 1'b1;
        pixel <= pix;
        frame_start <= starts_frame;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_window_mean(pix, starts_frame);
        pixels_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
        end
    endtask

    task automatic send_frame(input int unsigned count, input bit fresh,
                              input pixel_kind_t kind, input bit restarts);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(pick_pixel(kind),
                       (i == 0 && fresh) ||
                       (restarts && i > 0 && $urandom_range(0, 249) == 0));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_regs(input int unsigned radius_val, input int unsigned width_val,
                            input int unsigned recip_val, input bit touch_spare);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= REG_RADIUS;
        cfg_data <= with_junk(radius_val, RADIUS_BITS);
        @(posedge clk);
        cur_radius = RADIUS_BITS'(radius_val);
        cfg_index <= REG_LINE_WIDTH;
        cfg_data <= with_junk(width_val, WIDTH_BITS);
        @(posedge clk);
        cur_line_width = WIDTH_BITS'(width_val);
        cfg_index <= REG_RECIPROCAL;
        cfg_data <= CFG_DATA_BITS'(recip_val);
        @(posedge clk);
        cur_reciprocal = RECIP_BITS'(recip_val);
        if (touch_spare)
        begin
            cfg_index <= REG_UNUSED;
            cfg_data <= CFG_DATA_BITS'($urandom);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Radius and reciprocal keep their reset values; only the line is shortened.
    task automatic test_reset_values();
        cfg_write <= 1'b1;
        cfg_index <= REG_LINE_WIDTH;
        cfg_data <= CFG_DATA_BITS'(RESET_TEST_WIDTH);
        @(posedge clk);
        cur_line_width = WIDTH_BITS'(RESET_TEST_WIDTH);
        cfg_write <= 1'b0;
        send_frame(5 * RESET_TEST_WIDTH, 1'b0, PIX_MIXED, 1'b0);
    endtask

    task automatic test_field_extremes();
        set_regs(1, 3, area_reciprocal(3), 1'b1);
        send_frame(4 * 3, 1'b1, PIX_MAX, 1'b0);
        send_frame(4 * 3, 1'b1, PIX_ZERO, 1'b0);
        set_regs(1, 3, RECIP_MAX, 1'b0);
        send_frame(4 * 3, 1'b1, PIX_MIXED, 1'b0);
        set_regs(1, 4, 0, 1'b0);
        send_frame(4 * 4, 1'b1, PIX_MIXED, 1'b0);
    endtask

    task automatic test_radius_and_width_limits();
        set_regs(0, 5, area_reciprocal(3), 1'b0);
        send_frame(4 * 5, 1'b1, PIX_MIXED, 1'b0);
        set_regs(15, 17, area_reciprocal(17), 1'b0);
        send_frame(18 * 17, 1'b1, PIX_MIXED, 1'b0);
        set_regs(8, 16, area_reciprocal(17), 1'b0);
        send_frame(3 * 16, 1'b1, PIX_MIXED, 1'b0);
        set_regs(1, 2, area_reciprocal(3), 1'b0);
        send_frame(5 * 2, 1'b1, PIX_MIXED, 1'b0);
        set_regs(1, 0, area_reciprocal(3), 1'b0);
        send_frame(6, 1'b1, PIX_MIXED, 1'b0);
    endtask

    task automatic test_restart_mid_frame();
        set_regs(2, 7, area_reciprocal(5), 1'b0);
        send_frame(2 * 7 + 3, 1'b1, PIX_MIXED, 1'b0);
        send_frame(6 * 7, 1'b1, PIX_MIXED, 1'b0);
    endtask

    task automatic test_random_frames();
        int unsigned first_pixel;
        int unsigned r;
        int unsigned n;
        int unsigned w;
        int unsigned recip;
        int unsigned count;
        bit          fresh_settings;

        first_pixel = pixels_sent;
        fresh_settings = 1'b1;
        n = 3;
        w = 3;
        while (pixels_sent - first_pixel < RANDOM_ITEMS)
        begin
            if (fresh_settings || $urandom_range(0, 3) != 0)
            begin
                r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
                n = 2 * clamp_radius(r) + 1;
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1)
                                                 : n + $urandom_range(0, 12);
                case ($urandom_range(0, 5))
                    0:       recip = $urandom_range(0, RECIP_MAX);
                    1:       recip = RECIP_MAX;
                    default: recip = area_reciprocal(n);
                endcase
                set_regs(r, w, recip, $urandom_range(0, 7) == 0);
                fresh_settings = 1'b0;
            end
            count = (n + $urandom_range(0, 3)) * clamp_width(w);
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, count);
            send_frame(count, 1'b1, PIX_MIXED, 1'b1);
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_field_extremes();
        test_radius_and_width_limits();
        test_restart_mid_frame();
        test_random_frames();

        settle();
        mismatches += expected_means.size();
        $display("Sent %0d pixel beats and checked %0d mean beats over %0d register settings.",
                 pixels_sent, means_seen, settings_used);
        $display("Covered clamped radius and width, short lines, saturation, restarts ");
        $display("and random settings under bursty input and a stalling receiver.");
        if (mismatches == 0)
            $display("box_filter_sliding_sum_top test passed");
        else
            $display("box_filter_sliding_sum_top test failed");
        $finish;
    end

endmodule
